>>> src/iee_pkg.sv
package iee_pkg;

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_MOD    = 3'd5,
        OP_POW    = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_OVFL   = 2'd2,
        ST_MALF   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_DIGIT  = 3'd0,
        K_BINOP  = 3'd1,
        K_LPAREN = 3'd2,
        K_RPAREN = 3'd3,
        K_END    = 3'd4,
        K_BAD    = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        t_op        op;
        logic [3:0] digit;
    } t_token;

    localparam int unsigned TOKEN_W = $bits(t_token);

    function automatic logic [1:0] prec(input t_op op);
        case (op)
            OP_ADD, OP_SUB: prec = 2'd1;
            OP_POW:         prec = 2'd3;
            OP_LPAREN:      prec = 2'd0;
            default:        prec = 2'd2;
        endcase
    endfunction

endpackage

>>> src/iee_front.sv
module iee_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_char,
    input  logic                 i_end,
    output logic                 o_valid,
    input  logic                 i_ready,
    output iee_pkg::t_token      o_token
);

    iee_pkg::t_token w_tok;
    iee_pkg::t_token r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    always_comb begin
        w_tok.digit = i_char[3:0];
        w_tok.op    = iee_pkg::OP_LPAREN;
        w_tok.kind  = iee_pkg::K_BAD;
        if (i_end) begin
            w_tok.kind = iee_pkg::K_END;
        end else begin
            case (i_char)
                8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
                8'h35, 8'h36, 8'h37, 8'h38, 8'h39: w_tok.kind = iee_pkg::K_DIGIT;
                8'h2B: begin w_tok.kind = iee_pkg::K_BINOP; w_tok.op = iee_pkg::OP_ADD; end
                8'h2D: begin w_tok.kind = iee_pkg::K_BINOP; w_tok.op = iee_pkg::OP_SUB; end
                8'h2A: begin w_tok.kind = iee_pkg::K_BINOP; w_tok.op = iee_pkg::OP_MUL; end
                8'h2F: begin w_tok.kind = iee_pkg::K_BINOP; w_tok.op = iee_pkg::OP_DIV; end
                8'h25: begin w_tok.kind = iee_pkg::K_BINOP; w_tok.op = iee_pkg::OP_MOD; end
                8'h5E: begin w_tok.kind = iee_pkg::K_BINOP; w_tok.op = iee_pkg::OP_POW; end
                8'h28: w_tok.kind = iee_pkg::K_LPAREN;
                8'h29: w_tok.kind = iee_pkg::K_RPAREN;
                default: w_tok.kind = iee_pkg::K_BAD;
            endcase
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_token = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_q[r_wp] <= w_tok;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_valid && o_ready} - {1'b0, o_valid && i_ready};
        end
    end

endmodule

>>> src/iee_alu.sv
module iee_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  iee_pkg::t_op       i_op,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output logic               o_done,
    output logic [31:0]        o_res,
    output logic               o_div0
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_POW} t_state;

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic [31:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_d;
    logic [31:0] r_base;
    logic [31:0] r_ex;
    logic        r_na;
    logic        r_nb;
    iee_pkg::t_op r_op;
    logic [31:0] r_res;
    logic        r_done;
    logic        r_div0;

    logic [31:0] w_ua, w_ub;
    logic [32:0] w_trial;
    logic [32:0] w_sh;
    logic [63:0] w_pm, w_bm;

    assign w_ua    = i_a[31] ? 32'd0 - i_a : i_a;
    assign w_ub    = i_b[31] ? 32'd0 - i_b : i_b;
    assign w_sh    = {r_rem[31:0], r_q[31]};
    assign w_trial = w_sh - {1'b0, r_d};
    assign w_pm    = r_res * r_base;
    assign w_bm    = r_base * r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op   <= i_op;
                        r_div0 <= 1'b0;
                        r_cnt  <= 6'd0;
                        case (i_op)
                            iee_pkg::OP_ADD: begin r_res <= i_a + i_b; r_done <= 1'b1; end
                            iee_pkg::OP_SUB: begin r_res <= i_a - i_b; r_done <= 1'b1; end
                            iee_pkg::OP_MUL: begin
                                r_res  <= 32'(i_a * i_b);
                                r_done <= 1'b1;
                            end
                            iee_pkg::OP_DIV, iee_pkg::OP_MOD: begin
                                if (i_b == 32'd0) begin
                                    r_div0 <= 1'b1;
                                    r_done <= 1'b1;
                                end else begin
                                    r_q     <= w_ua;
                                    r_rem   <= 33'd0;
                                    r_d     <= w_ub;
                                    r_na    <= i_a[31];
                                    r_nb    <= i_b[31];
                                    r_state <= S_DIV;
                                end
                            end
                            iee_pkg::OP_POW: begin
                                if (i_b[31]) begin
                                    if (i_a == 32'd1) r_res <= 32'd1;
                                    else if (i_a == 32'hFFFF_FFFF)
                                        r_res <= i_b[0] ? 32'hFFFF_FFFF : 32'd1;
                                    else r_res <= 32'd0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_res   <= 32'd1;
                                    r_base  <= i_a;
                                    r_ex    <= i_b;
                                    r_state <= S_POW;
                                end
                            end
                            default: begin r_res <= 32'd0; r_done <= 1'b1; end
                        endcase
                    end
                end
                S_DIV: begin
                    if (!w_trial[32]) begin
                        r_rem <= w_trial;
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= w_sh;
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                S_POW: begin
                    if (r_ex[0]) r_res <= w_pm[31:0];
                    r_base <= w_bm[31:0];
                    r_ex   <= {1'b0, r_ex[31:1]};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd30 || r_ex[31:1] == 31'd0) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_res = r_res;
        if (r_op == iee_pkg::OP_DIV) begin
            o_res = (r_na != r_nb) ? 32'd0 - r_q : r_q;
        end else if (r_op == iee_pkg::OP_MOD) begin
            o_res = r_na ? 32'd0 - r_rem[31:0] : r_rem[31:0];
        end
    end

    assign o_done = r_done;
    assign o_div0 = r_div0;

endmodule

>>> src/iee_back.sv
module iee_back #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  iee_pkg::t_token i_token,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_value,
    output logic [1:0]      o_status
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PUSHNUM, S_DISPATCH, S_LOOP, S_RD, S_RDW, S_ALU, S_WAIT,
        S_WB, S_FINAL, S_FINRD, S_OUT
    } t_state;

    t_state          r_state;
    iee_pkg::t_token r_tok;
    logic [31:0]     r_acc;
    logic            r_pend;
    iee_pkg::t_status r_err;
    logic [CW-1:0]   r_ntop;
    logic [CW-1:0]   r_otop;
    iee_pkg::t_op    r_optop;
    logic [31:0]     r_a, r_b;
    logic            r_start;
    logic            r_ovalid;
    logic [31:0]     r_value;
    logic [1:0]      r_status;

    logic [31:0]     r_nmem [STACK_DEPTH];
    logic [2:0]      r_omem [STACK_DEPTH];
    logic [31:0]     r_nrd;
    logic [2:0]      r_ord;

    logic            w_nwe;
    logic [AW-1:0]   w_nwa;
    logic [31:0]     w_nwd;
    logic [AW-1:0]   w_nra;
    logic            w_owe;
    logic [AW-1:0]   w_owa;
    logic [2:0]      w_owd;
    logic [AW-1:0]   w_ora;

    logic            w_done;
    logic [31:0]     w_res;
    logic            w_div0;
    logic [35:0]     w_mul10;

    iee_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_op    (r_optop),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (w_done),
        .o_res   (w_res),
        .o_div0  (w_div0)
    );

    assign w_mul10 = {4'd0, r_acc} * 36'd10 + {32'd0, r_tok.digit};
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_value = r_value;
    assign o_status = r_status;

    always_ff @(posedge i_clk) begin
        if (w_nwe) r_nmem[w_nwa] <= w_nwd;
        r_nrd <= r_nmem[w_nra];
        if (w_owe) r_omem[w_owa] <= w_owd;
        r_ord <= r_omem[w_ora];
    end

    always_comb begin
        w_nwe = 1'b0;
        w_nwa = r_ntop[AW-1:0];
        w_nwd = r_acc;
        w_owe = 1'b0;
        w_owa = r_otop[AW-1:0];
        w_owd = r_tok.op;
        w_nra = r_ntop[AW-1:0] - AW'(1);
        w_ora = r_otop[AW-1:0] - AW'(1);
        if (r_state == S_PUSHNUM && r_err == iee_pkg::ST_OK && r_pend
            && r_ntop < CW'(STACK_DEPTH)) begin
            w_nwe = 1'b1;
        end
        if (r_state == S_DISPATCH && r_err == iee_pkg::ST_OK
            && r_otop < CW'(STACK_DEPTH)
            && (r_tok.kind == iee_pkg::K_LPAREN)) begin
            w_owe = 1'b1;
            w_owd = iee_pkg::OP_LPAREN;
        end
        if (r_state == S_LOOP && r_tok.kind == iee_pkg::K_BINOP && r_err == iee_pkg::ST_OK
            && r_otop < CW'(STACK_DEPTH) && (r_otop == CW'(0) || !(
            r_optop != iee_pkg::OP_LPAREN && (iee_pkg::prec(r_optop) > iee_pkg::prec(r_tok.op)
            || (iee_pkg::prec(r_optop) == iee_pkg::prec(r_tok.op)
            && r_tok.op != iee_pkg::OP_POW))))) begin
            w_owe = 1'b1;
        end
        if (r_state == S_RD) w_nra = r_ntop[AW-1:0] - AW'(2);
        if (r_state == S_WB && !w_div0) begin
            w_nwe = 1'b1;
            w_nwa = r_ntop[AW-1:0] - AW'(2);
            w_nwd = w_res;
        end
        if (r_state == S_WB) w_ora = r_otop[AW-1:0] - AW'(2);
        if (r_state == S_FINAL || r_state == S_FINRD) w_nra = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= 32'd0;
            r_pend   <= 1'b0;
            r_err    <= iee_pkg::ST_OK;
            r_ntop   <= '0;
            r_otop   <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= (r_state == S_RDW);
            if (r_ovalid && i_ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tok   <= i_token;
                        r_state <= S_PUSHNUM;
                    end
                end
                S_PUSHNUM: begin
                    if (r_tok.kind == iee_pkg::K_DIGIT) begin
                        if (r_err == iee_pkg::ST_OK) begin
                            r_acc  <= w_mul10[31:0];
                            r_pend <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        if (r_err == iee_pkg::ST_OK && r_pend) begin
                            if (r_ntop < CW'(STACK_DEPTH)) r_ntop <= r_ntop + CW'(1);
                            else r_err <= iee_pkg::ST_OVFL;
                        end
                        r_acc   <= 32'd0;
                        r_pend  <= 1'b0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_optop <= iee_pkg::t_op'(r_ord);
                    if (r_err != iee_pkg::ST_OK) begin
                        r_state <= (r_tok.kind == iee_pkg::K_END) ? S_OUT : S_IDLE;
                    end else begin
                        unique case (r_tok.kind)
                            iee_pkg::K_LPAREN: begin
                                if (r_otop < CW'(STACK_DEPTH)) r_otop <= r_otop + CW'(1);
                                else r_err <= iee_pkg::ST_OVFL;
                                r_state <= S_IDLE;
                            end
                            iee_pkg::K_BAD: begin
                                r_err   <= iee_pkg::ST_MALF;
                                r_state <= S_IDLE;
                            end
                            default: r_state <= S_LOOP;
                        endcase
                    end
                end
                S_LOOP: begin
                    if (r_err != iee_pkg::ST_OK) begin
                        r_state <= (r_tok.kind == iee_pkg::K_END) ? S_OUT : S_IDLE;
                    end else if (r_otop == CW'(0)) begin
                        case (r_tok.kind)
                            iee_pkg::K_BINOP: begin
                                if (r_otop < CW'(STACK_DEPTH)) r_otop <= r_otop + CW'(1);
                                else r_err <= iee_pkg::ST_OVFL;
                                r_state <= S_IDLE;
                            end
                            iee_pkg::K_RPAREN: begin
                                r_err   <= iee_pkg::ST_MALF;
                                r_state <= S_IDLE;
                            end
                            default: r_state <= S_FINAL;
                        endcase
                    end else if (r_optop == iee_pkg::OP_LPAREN) begin
                        case (r_tok.kind)
                            iee_pkg::K_BINOP: begin
                                if (r_otop < CW'(STACK_DEPTH)) r_otop <= r_otop + CW'(1);
                                else r_err <= iee_pkg::ST_OVFL;
                                r_state <= S_IDLE;
                            end
                            iee_pkg::K_RPAREN: begin
                                r_otop  <= r_otop - CW'(1);
                                r_state <= S_IDLE;
                            end
                            default: begin
                                r_err   <= iee_pkg::ST_MALF;
                                r_state <= S_OUT;
                            end
                        endcase
                    end else if (r_tok.kind == iee_pkg::K_BINOP
                        && !(iee_pkg::prec(r_optop) > iee_pkg::prec(r_tok.op)
                        || (iee_pkg::prec(r_optop) == iee_pkg::prec(r_tok.op)
                        && r_tok.op != iee_pkg::OP_POW))) begin
                        if (r_otop < CW'(STACK_DEPTH)) r_otop <= r_otop + CW'(1);
                        else r_err <= iee_pkg::ST_OVFL;
                        r_state <= S_IDLE;
                    end else if (r_ntop < CW'(2)) begin
                        r_err   <= iee_pkg::ST_MALF;
                        r_state <= (r_tok.kind == iee_pkg::K_END) ? S_OUT : S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_b     <= r_nrd;
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_a     <= r_nrd;
                    r_state <= S_ALU;
                end
                S_ALU: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) r_state <= S_WB;
                end
                S_WB: begin
                    if (w_div0) begin
                        r_err   <= iee_pkg::ST_DIV0;
                        r_state <= (r_tok.kind == iee_pkg::K_END) ? S_OUT : S_IDLE;
                    end else begin
                        r_ntop  <= r_ntop - CW'(1);
                        r_otop  <= r_otop - CW'(1);
                        r_state <= S_DISPATCH;
                    end
                end
                S_FINAL: begin
                    if (r_ntop != CW'(1)) begin
                        r_err   <= iee_pkg::ST_MALF;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FINRD;
                    end
                end
                S_FINRD: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_status <= r_err;
                        r_value  <= (r_err == iee_pkg::ST_OK) ? r_nrd : 32'd0;
                        r_err    <= iee_pkg::ST_OK;
                        r_ntop   <= '0;
                        r_otop   <= '0;
                        r_acc    <= 32'd0;
                        r_pend   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/infix_expression_evaluator_unit.sv
// Each reduction in the execution engine waits on the ALU, which iterates
// for a divide, modulo or power; a beat is registered in the queue before the engine can take it.
// Throughput: one beat at a time in the execution engine, which takes a beat only while idle;
// a two-entry queue after the classifier absorbs input while the engine works.
// Reset: synchronous, active low; both stacks are empty and the error state is clear after reset.
module infix_expression_evaluator_unit #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // end_of_expr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // value[31:0], status[33:32], zero fill
);

    logic            w_qvalid;
    logic            w_qready;
    iee_pkg::t_token w_tok;
    logic [31:0]     w_value;
    logic [1:0]      w_status;

    iee_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_char  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .o_valid (w_qvalid),
        .i_ready (w_qready),
        .o_token (w_tok)
    );

    iee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .o_ready  (w_qready),
        .i_token  (w_tok),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (w_value),
        .o_status (w_status)
    );

    assign m_axis_tdata = {6'd0, w_status, w_value};

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33:32] != iee_pkg::ST_OK |-> m_axis_tdata[31:0] == 32'd0)
        else $error("error result with nonzero value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_qflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qvalid && w_qready |=> !w_qready)
        else $error("engine took two beats back to back");

endmodule
